### src/sobel_pkg.sv
// ---------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants for the rgb sobel edge magnitude block.
// ---------------------------------------------------------------------------
package sobel_pkg;

   localparam int unsigned MAX_LINE_PIXELS_DEF = 1024;
   localparam int unsigned ROWS_LIMIT          = 4096;
   localparam int unsigned PIX_W               = 24;
   localparam int unsigned CSR_IDX_W           = 2;
   localparam int unsigned CSR_DATA_W          = 13;
   localparam int unsigned WIDTH_REG_W         = 11;
   localparam int unsigned HEIGHT_REG_W        = 13;
   localparam int unsigned GRAD_W              = 11;
   localparam int unsigned SUM_W               = 21;
   localparam int unsigned ROOT_W              = 9;
   localparam int unsigned ROOT_STEPS          = 9;
   localparam int unsigned IDX_W               = 4;

   // above this sum the rounded root is at least 255
   localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(65280);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_PAD   = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_GRAD   = 6'b000100,
      ST_SQUARE = 6'b001000,
      ST_ROOT   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic grad;
      logic square;
      logic root_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic root_last;
      logic out_busy;
   } status_type;

endpackage

### src/sobel_edge_magnitude_rgb_top.sv
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// 3x3 sobel gradient magnitude per colour channel on a raster rgb stream.
// ---------------------------------------------------------------------------
// Pixels arrive in raster order, one transaction each; after the last pixel
// of a frame send frame_width+1 pad transactions. The result for a pixel
// leaves with the transaction frame_width+1 items later, frame_last marks the
// final one. An item that produces a result goes through accept, line
// store read, gradient, square, nine steps of the shared root unit (one bit
// per step, all three channels together) and output load. An item with no
// result ends at gradient. One item is in work at a time; a finished result
// waits in the output register while the next item is taken. Line stores are
// not cleared after reset: reads of unwritten entries are masked by row.
module sobel_edge_magnitude_rgb_top #(
   parameter int unsigned MAX_LINE_PIXELS = sobel_pkg::MAX_LINE_PIXELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [7:0]                       req_red_in,
   input  logic [7:0]                       req_green_in,
   input  logic [7:0]                       req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_red_edge,
   output logic [7:0]                       rsp_green_edge,
   output logic [7:0]                       rsp_blue_edge,
   output logic                             rsp_frame_last,
   input  logic                             csr_write,
   input  logic [sobel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0] csr_data
);

   sobel_pkg::cmd_type    cmd;
   sobel_pkg::status_type status;

   sobel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sobel_dp #(.MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_cmd        (req_cmd),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_edge   (rsp_red_edge),
      .rsp_green_edge (rsp_green_edge),
      .rsp_blue_edge  (rsp_blue_edge),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

### src/sobel_ram.sv
// ---------------------------------------------------------------------------
// sobel_ram
// Generic single write, single read ram with registered read data.
// ---------------------------------------------------------------------------
module sobel_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sobel_ctrl.sv
// ---------------------------------------------------------------------------
// sobel_ctrl
// Sequencer: accept, line store read, gradient, square, root steps, output.
// ---------------------------------------------------------------------------
module sobel_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sobel_pkg::status_type status,
   output sobel_pkg::cmd_type    cmd
);

   sobel_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         sobel_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sobel_pkg::ST_READ;
            end
         end
         sobel_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = sobel_pkg::ST_GRAD;
         end
         sobel_pkg::ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = status.emit ? sobel_pkg::ST_SQUARE : sobel_pkg::ST_IDLE;
         end
         sobel_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = sobel_pkg::ST_ROOT;
         end
         sobel_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = sobel_pkg::ST_DONE;
            end
         end
         sobel_pkg::ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = sobel_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sobel_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sobel_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != sobel_pkg::ST_IDLE);

endmodule

### src/sobel_dp.sv
// ---------------------------------------------------------------------------
// sobel_dp
// Datapath: position counters, line stores, window, gradients, iterative root.
// ---------------------------------------------------------------------------
module sobel_dp #(
   parameter int unsigned MAX_LINE_PIXELS = sobel_pkg::MAX_LINE_PIXELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sobel_pkg::cmd_type                   cmd,
   output sobel_pkg::status_type                status,
   input  logic                                 req_cmd,
   input  logic [7:0]                           req_red_in,
   input  logic [7:0]                           req_green_in,
   input  logic [7:0]                           req_blue_in,
   input  logic                                 csr_write,
   input  logic [sobel_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_red_edge,
   output logic [7:0]                           rsp_green_edge,
   output logic [7:0]                           rsp_blue_edge,
   output logic                                 rsp_frame_last
);

   localparam int unsigned AW  = $clog2(MAX_LINE_PIXELS);
   localparam int unsigned CW  = $clog2(MAX_LINE_PIXELS + 1);
   localparam int unsigned HW  = sobel_pkg::HEIGHT_REG_W;
   localparam int unsigned PW  = sobel_pkg::PIX_W;
   localparam int unsigned GW  = sobel_pkg::GRAD_W;
   localparam int unsigned SW  = sobel_pkg::SUM_W;
   localparam int unsigned RW  = sobel_pkg::ROOT_W;
   localparam int unsigned XW  = sobel_pkg::IDX_W;

   // gradient of one channel; columns a (left), b (middle), c (right), rows 0..2
   function automatic logic [2*GW-1:0] grad_xy(
      input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
      input logic [7:0] b0, input logic [7:0] b2,
      input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2
   );
      logic signed [GW-1:0] gx;
      logic signed [GW-1:0] gy;
      gx = $signed({3'b000, c0}) - $signed({3'b000, a0})
         + $signed({2'b00, c1, 1'b0}) - $signed({2'b00, a1, 1'b0})
         + $signed({3'b000, c2}) - $signed({3'b000, a2});
      gy = $signed({3'b000, a2}) + $signed({2'b00, b2, 1'b0}) + $signed({3'b000, c2})
         - $signed({3'b000, a0}) - $signed({2'b00, b0, 1'b0}) - $signed({3'b000, c0});
      return {gx, gy};
   endfunction

   function automatic logic [GW-2:0] mag(input logic signed [GW-1:0] g);
      logic [GW-1:0] a;
      a = g[GW-1] ? GW'(-g) : GW'(g);
      return a[GW-2:0];
   endfunction

   logic [sobel_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [HW-1:0]                     height_ff;
   logic [CW-1:0]                     col_ff;
   logic [HW-1:0]                     row_ff;
   logic                              cmd_ff;
   logic [PW-1:0]                     pix_ff;
   logic [PW-1:0]                     win0_ff [3];
   logic [PW-1:0]                     win1_ff [3];
   logic                              emit_ff;
   logic                              last_ff;
   logic signed [GW-1:0]              gx_ff [3];
   logic signed [GW-1:0]              gy_ff [3];
   logic [SW-1:0]                     sum_ff [3];
   logic [RW-1:0]                     root_ff [3];
   logic [XW-1:0]                     idx_ff;
   logic                              rsp_valid_ff;
   logic [7:0]                        edge_ff [3];
   logic                              frame_last_ff;

   logic [CW-1:0]    eff_w;
   logic [HW-1:0]    eff_h;
   logic [CW-1:0]    c_eff;
   logic [AW-1:0]    addr;
   logic [HW:0]      r_x;
   logic [HW:0]      h_x;
   logic             upper_ok;
   logic             mid_ok;
   logic             pix_ok;
   logic [PW-1:0]    up_rd;
   logic [PW-1:0]    mid_rd;
   logic [PW-1:0]    ncol [3];
   logic [PW-1:0]    wa [3];
   logic [PW-1:0]    wb [3];
   logic [PW-1:0]    wc [3];
   logic             emit;
   logic             last;
   logic [CW:0]      c_next;
   logic [CW-1:0]    col_in;
   logic [HW-1:0]    row_in;
   logic [2*GW-1:0]  g [3];
   logic [RW-1:0]    bit_mask;
   logic [RW-1:0]    trial [3];
   logic [2*RW-1:0]  round_lim [3];
   logic [RW:0]      rounded [3];
   logic [7:0]       edge_in [3];

   always_comb begin
      if (width_ff == '0) begin
         eff_w = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_LINE_PIXELS)) begin
         eff_w = CW'(MAX_LINE_PIXELS);
      end else begin
         eff_w = CW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(height_ff) > 32'(sobel_pkg::ROWS_LIMIT)) begin
         eff_h = HW'(sobel_pkg::ROWS_LIMIT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign c_eff = (col_ff >= eff_w) ? '0 : col_ff;
   assign addr  = c_eff[AW-1:0];
   assign r_x   = {1'b0, row_ff};
   assign h_x   = {1'b0, eff_h};

   assign upper_ok = (r_x >= (HW+1)'(2)) && (r_x <= h_x + (HW+1)'(1));
   assign mid_ok   = (r_x >= (HW+1)'(1)) && (r_x <= h_x);
   assign pix_ok   = (cmd_ff == sobel_pkg::CMD_PIXEL) && (r_x < h_x);

   sobel_ram #(.WIDTH(PW), .DEPTH(MAX_LINE_PIXELS)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.grad),
      .wr_addr (addr),
      .wr_data (mid_rd),
      .rd_en   (cmd.read),
      .rd_addr (addr),
      .rd_data (up_rd)
   );

   sobel_ram #(.WIDTH(PW), .DEPTH(MAX_LINE_PIXELS)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.grad),
      .wr_addr (addr),
      .wr_data (ncol[2]),
      .rd_en   (cmd.read),
      .rd_addr (addr),
      .rd_data (mid_rd)
   );

   // window columns; left column empty at the left frame edge, right column at the right
   always_comb begin
      ncol[0] = upper_ok ? up_rd : '0;
      ncol[1] = mid_ok ? mid_rd : '0;
      ncol[2] = pix_ok ? pix_ff : '0;
      for (int i = 0; i < 3; i++) begin
         wb[i] = win1_ff[i];
         if (c_eff != '0) begin
            wa[i] = (c_eff >= CW'(2)) ? win0_ff[i] : '0;
            wc[i] = ncol[i];
         end else begin
            wa[i] = (eff_w >= CW'(2)) ? win0_ff[i] : '0;
            wc[i] = '0;
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         g[ch] = grad_xy(wa[0][8*(2-ch) +: 8], wa[1][8*(2-ch) +: 8], wa[2][8*(2-ch) +: 8],
                         wb[0][8*(2-ch) +: 8], wb[2][8*(2-ch) +: 8],
                         wc[0][8*(2-ch) +: 8], wc[1][8*(2-ch) +: 8], wc[2][8*(2-ch) +: 8]);
      end
   end

   assign emit = (row_ff >= HW'(2)) || ((row_ff == HW'(1)) && (c_eff != '0));
   assign last = (r_x == h_x + (HW+1)'(1));

   always_comb begin
      c_next = {1'b0, c_eff} + (CW+1)'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (c_next >= {1'b0, eff_w}) begin
         col_in = '0;
         row_in = row_ff + HW'(1);
      end else begin
         col_in = c_next[CW-1:0];
      end
   end

   // one bit of each root per step, msb first
   assign bit_mask = RW'(1) << idx_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         trial[ch]     = root_ff[ch] | bit_mask;
         round_lim[ch] = root_ff[ch] * root_ff[ch] + (2*RW)'(root_ff[ch]);
         if (sum_ff[ch] > SW'(round_lim[ch])) begin
            rounded[ch] = {1'b0, root_ff[ch]} + (RW+1)'(1);
         end else begin
            rounded[ch] = {1'b0, root_ff[ch]};
         end
         if (sum_ff[ch] > sobel_pkg::SUM_LIMIT || rounded[ch] > (RW+1)'(255)) begin
            edge_in[ch] = 8'hff;
         end else begin
            edge_in[ch] = rounded[ch][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= sobel_pkg::WIDTH_REG_W'(640);
         height_ff    <= HW'(480);
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win0_ff[i] <= '0;
            win1_ff[i] <= '0;
         end
      end else begin
         if (csr_write && csr_index == sobel_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= csr_data[sobel_pkg::WIDTH_REG_W-1:0];
            col_ff   <= '0;
            row_ff   <= '0;
         end else if (csr_write && csr_index == sobel_pkg::CSR_FRAME_HEIGHT) begin
            height_ff <= csr_data[HW-1:0];
            col_ff    <= '0;
            row_ff    <= '0;
         end else if (cmd.grad) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (cmd.grad) begin
            for (int i = 0; i < 3; i++) begin
               win0_ff[i] <= win1_ff[i];
               win1_ff[i] <= ncol[i];
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_cmd;
         pix_ff <= {req_red_in, req_green_in, req_blue_in};
      end
      if (cmd.grad) begin
         emit_ff <= emit;
         last_ff <= last;
         for (int ch = 0; ch < 3; ch++) begin
            gx_ff[ch] <= $signed(g[ch][2*GW-1:GW]);
            gy_ff[ch] <= $signed(g[ch][GW-1:0]);
         end
      end
      if (cmd.square) begin
         idx_ff <= XW'(sobel_pkg::ROOT_STEPS - 1);
         for (int ch = 0; ch < 3; ch++) begin
            sum_ff[ch]  <= SW'(mag(gx_ff[ch])) * SW'(mag(gx_ff[ch]))
                         + SW'(mag(gy_ff[ch])) * SW'(mag(gy_ff[ch]));
            root_ff[ch] <= '0;
         end
      end
      if (cmd.root_step) begin
         idx_ff <= idx_ff - XW'(1);
         for (int ch = 0; ch < 3; ch++) begin
            if (SW'(trial[ch]) * SW'(trial[ch]) <= sum_ff[ch]) begin
               root_ff[ch] <= trial[ch];
            end
         end
      end
      if (cmd.load_out) begin
         frame_last_ff <= last_ff;
         for (int ch = 0; ch < 3; ch++) begin
            edge_ff[ch] <= edge_in[ch];
         end
      end
   end

   assign status.emit      = emit;
   assign status.root_last = (idx_ff == '0);
   assign status.out_busy  = rsp_valid_ff && rsp_stall && emit_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_edge   = edge_ff[0];
   assign rsp_green_edge = edge_ff[1];
   assign rsp_blue_edge  = edge_ff[2];
   assign rsp_frame_last = frame_last_ff;

endmodule
